/* hdl/hsrk_pkg.sv */
// Shared item types, command codes and datapath operation codes for the record heap sorter.
`default_nettype none
package hsrk_pkg;

   localparam int KEY_W = 32;

   // Command codes carried in the cmd field of an input item.
   localparam logic [1:0] CMD_LOAD  = 2'd0;
   localparam logic [1:0] CMD_CLEAR = 2'd1;
   localparam logic [1:0] CMD_SORT  = 2'd2;
   // The remaining code is accepted and ignored.
   localparam logic [1:0] CMD_NONE  = 2'd3;

   // Key select codes; KEY_SEL_A and KEY_SEL_ALT both select the third score.
   localparam logic [1:0] KEY_SEL_R   = 2'd0;
   localparam logic [1:0] KEY_SEL_D   = 2'd1;
   localparam logic [1:0] KEY_SEL_A   = 2'd2;
   localparam logic [1:0] KEY_SEL_ALT = 2'd3;

   typedef struct packed {
      logic [1:0]         cmd;
      logic [15:0]        record_id;
      logic signed [31:0] score_r;
      logic signed [31:0] score_d;
      logic signed [31:0] score_a;
      logic [1:0]         key_select;
   } req_type;

   typedef struct packed {
      logic [15:0]        out_id;
      logic signed [31:0] out_score_r;
      logic signed [31:0] out_score_d;
      logic signed [31:0] out_score_a;
      logic               last;
   } rsp_type;

   // One stored record.
   typedef struct packed {
      logic [15:0] id;
      logic [31:0] score_r;
      logic [31:0] score_d;
      logic [31:0] score_a;
   } rec_type;

   // Operation that the controller asks of the datapath in one cycle.
   typedef enum logic [4:0] {
      OP_IDLE,
      OP_LOAD,
      OP_CLEAR,
      OP_START,
      OP_FILL_RD,
      OP_FILL_WR,
      OP_BUILD_INIT,
      OP_BUILD_RD,
      OP_LOAD_CUR,
      OP_SIFT_RDL,
      OP_SIFT_RDR,
      OP_SIFT_CMP,
      OP_SIFT_PUT,
      OP_EX_RDM,
      OP_EX_RD0,
      OP_EX_WRM,
      OP_EM_INIT,
      OP_EM_RD,
      OP_EM_RREC,
      OP_EM_OUT
   } op_type;

   // Status returned from the datapath to the controller.
   typedef struct packed {
      logic hsize_zero;
      logic hsize_one;
      logic fill_last;
      logic j_zero;
      logic l_ok;
      logic sift_stop;
      logic out_free;
      logic em_last;
   } stat_type;

   // Sort key of a record, sign bit flipped so that an unsigned compare orders signed scores.
   function automatic logic [KEY_W-1:0] key_of(rec_type rec, logic [1:0] sel);
      logic [KEY_W-1:0] v;
      if (sel == KEY_SEL_R) begin
         v = rec.score_r;
      end else if (sel == KEY_SEL_D) begin
         v = rec.score_d;
      end else begin
         v = rec.score_a;
      end
      return {~v[KEY_W-1], v[KEY_W-2:0]};
   endfunction

endpackage
`default_nettype wire

/* hdl/hsrk_dp.sv */
// Datapath of the record heap sorter: record store, heap memory, counters and output register.
`default_nettype none
module hsrk_dp #(
   parameter int MAX_RECORDS = 64
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire hsrk_pkg::op_type  op,
   input  wire hsrk_pkg::req_type req,
   output hsrk_pkg::stat_type     stat,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output hsrk_pkg::rsp_type      rsp
);
   import hsrk_pkg::*;

   localparam int IDX_W = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
   localparam int CNT_W = IDX_W + 1;
   localparam int POS_W = IDX_W + 2;

   // A heap entry carries the record index and a copy of its key.
   typedef struct packed {
      logic [IDX_W-1:0] idx;
      logic [KEY_W-1:0] key;
   } hent_type;

   rec_type  rec_mem  [MAX_RECORDS];
   hent_type heap_mem [MAX_RECORDS];
   rec_type  rec_rd_ff;
   hent_type heap_rd_ff;

   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] hsize_ff, hsize_in;
   logic [CNT_W-1:0] j_ff, j_in;
   logic [IDX_W-1:0] i_ff, i_in;
   logic [1:0]       sel_ff, sel_in;
   hent_type         cur_ff, cur_in;
   hent_type         lval_ff, lval_in;
   rsp_type          out_ff, out_in;
   logic             rsp_valid_ff, rsp_valid_in;

   logic             rec_we, rec_re, heap_we, heap_re;
   logic [IDX_W-1:0] rec_raddr, heap_raddr, heap_waddr;
   hent_type         heap_wdata;
   rec_type          rec_wdata;

   logic [POS_W-1:0] l_pos, r_pos, hsize_ext;
   logic [CNT_W-1:0] j_m1, hsize_m1, count_m1;
   logic             l_ok, r_ok, l_lt, r_lt, sift_stop, out_free, store_full;
   logic [KEY_W-1:0] small_key;
   hent_type         child;
   logic [IDX_W-1:0] child_pos;

   // Child positions and the sift-down comparison against the carried entry.
   always_comb begin
      l_pos     = {{(POS_W-IDX_W-1){1'b0}}, i_ff, 1'b1};
      r_pos     = l_pos + POS_W'(1);
      hsize_ext = POS_W'(hsize_ff);
      l_ok      = l_pos < hsize_ext;
      r_ok      = r_pos < hsize_ext;
      l_lt      = lval_ff.key < cur_ff.key;
      small_key = l_lt ? lval_ff.key : cur_ff.key;
      r_lt      = r_ok && (heap_rd_ff.key < small_key);
      sift_stop = !l_lt && !r_lt;
      child     = r_lt ? heap_rd_ff : lval_ff;
      child_pos = r_lt ? r_pos[IDX_W-1:0] : l_pos[IDX_W-1:0];
      j_m1      = j_ff - CNT_W'(1);
      hsize_m1  = hsize_ff - CNT_W'(1);
      count_m1  = count_ff - CNT_W'(1);
      out_free  = !rsp_valid_ff || !rsp_stall;
      store_full = count_ff >= CNT_W'(MAX_RECORDS);
   end

   // Memory port control for each operation.
   always_comb begin
      rec_we     = 1'b0;
      rec_re     = 1'b0;
      rec_raddr  = j_ff[IDX_W-1:0];
      rec_wdata  = {req.record_id, req.score_r, req.score_d, req.score_a};
      heap_we    = 1'b0;
      heap_re    = 1'b0;
      heap_raddr = j_ff[IDX_W-1:0];
      heap_waddr = i_ff;
      heap_wdata = cur_ff;
      unique case (op)
         OP_LOAD: begin
            rec_we = !store_full;
         end
         OP_FILL_RD: begin
            rec_re = 1'b1;
         end
         OP_FILL_WR: begin
            heap_we    = 1'b1;
            heap_waddr = j_ff[IDX_W-1:0];
            heap_wdata = {j_ff[IDX_W-1:0], key_of(rec_rd_ff, sel_ff)};
         end
         OP_BUILD_RD: begin
            heap_re    = 1'b1;
            heap_raddr = j_m1[IDX_W-1:0];
         end
         OP_SIFT_RDL: begin
            heap_re    = 1'b1;
            heap_raddr = l_pos[IDX_W-1:0];
         end
         OP_SIFT_RDR: begin
            heap_re    = r_ok;
            heap_raddr = r_pos[IDX_W-1:0];
         end
         OP_SIFT_CMP: begin
            heap_we    = 1'b1;
            heap_wdata = sift_stop ? cur_ff : child;
         end
         OP_SIFT_PUT: begin
            heap_we = 1'b1;
         end
         OP_EX_RDM: begin
            heap_re    = 1'b1;
            heap_raddr = hsize_m1[IDX_W-1:0];
         end
         OP_EX_RD0: begin
            heap_re    = 1'b1;
            heap_raddr = '0;
         end
         OP_EX_WRM: begin
            heap_we    = 1'b1;
            heap_waddr = hsize_ff[IDX_W-1:0];
            heap_wdata = heap_rd_ff;
         end
         OP_EM_RD: begin
            heap_re = 1'b1;
         end
         OP_EM_RREC: begin
            rec_re    = 1'b1;
            rec_raddr = heap_rd_ff.idx;
         end
         default: begin
         end
      endcase
   end

   // Record store and heap memory, each with a registered read.
   always_ff @(posedge clock) begin
      if (rec_we) begin
         rec_mem[count_ff[IDX_W-1:0]] <= rec_wdata;
      end
      if (rec_re) begin
         rec_rd_ff <= rec_mem[rec_raddr];
      end
      if (heap_we) begin
         heap_mem[heap_waddr] <= heap_wdata;
      end
      if (heap_re) begin
         heap_rd_ff <= heap_mem[heap_raddr];
      end
   end

   // Next values of counters and working registers.
   always_comb begin
      count_in     = count_ff;
      hsize_in     = hsize_ff;
      j_in         = j_ff;
      i_in         = i_ff;
      sel_in       = sel_ff;
      cur_in       = cur_ff;
      lval_in      = lval_ff;
      out_in       = out_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (op)
         OP_LOAD: begin
            if (!store_full) begin
               count_in = count_ff + CNT_W'(1);
            end
         end
         OP_CLEAR: begin
            count_in = '0;
         end
         OP_START: begin
            sel_in   = req.key_select;
            hsize_in = count_ff;
            j_in     = '0;
         end
         OP_FILL_WR: begin
            j_in = j_ff + CNT_W'(1);
         end
         OP_BUILD_INIT: begin
            j_in = hsize_ff >> 1;
         end
         OP_BUILD_RD: begin
            j_in = j_m1;
            i_in = j_m1[IDX_W-1:0];
         end
         OP_LOAD_CUR: begin
            cur_in = heap_rd_ff;
         end
         OP_SIFT_RDR: begin
            lval_in = heap_rd_ff;
         end
         OP_SIFT_CMP: begin
            if (!sift_stop) begin
               i_in = child_pos;
            end
         end
         OP_EX_RDM: begin
            hsize_in = hsize_m1;
         end
         OP_EX_RD0: begin
            cur_in = heap_rd_ff;
         end
         OP_EX_WRM: begin
            i_in = '0;
         end
         OP_EM_INIT: begin
            j_in = '0;
         end
         OP_EM_OUT: begin
            j_in = j_ff + CNT_W'(1);
            out_in = {rec_rd_ff.id, rec_rd_ff.score_r, rec_rd_ff.score_d,
                      rec_rd_ff.score_a, (j_ff == count_m1)};
            rsp_valid_in = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      hsize_ff <= hsize_in;
      j_ff     <= j_in;
      i_ff     <= i_in;
      sel_ff   <= sel_in;
      cur_ff   <= cur_in;
      lval_ff  <= lval_in;
      out_ff   <= out_in;
   end

   // Status to the controller.
   always_comb begin
      stat.hsize_zero = hsize_ff == '0;
      stat.hsize_one  = hsize_ff == CNT_W'(1);
      stat.fill_last  = j_ff == hsize_m1;
      stat.j_zero     = j_ff == '0;
      stat.l_ok       = l_ok;
      stat.sift_stop  = sift_stop;
      stat.out_free   = out_free;
      stat.em_last    = j_ff == count_m1;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = out_ff;

`ifndef NO_ASSERTIONS
   // A new item never overwrites a result that is still waiting.
   a_out_free: assert property (@(posedge clock) disable iff (reset)
      (op == OP_EM_OUT) |-> (!rsp_valid_ff || !rsp_stall))
      else $error("output register overwritten while stalled");

   // The store never holds more records than it has entries.
   a_count_max: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_RECORDS))
      else $error("record count beyond store depth");

   // A sift compare only happens with a left child inside the heap.
   a_cmp_child: assert property (@(posedge clock) disable iff (reset)
      (op == OP_SIFT_CMP) |-> l_ok)
      else $error("sift compare without a left child");
`endif

endmodule
`default_nettype wire

/* hdl/hsrk_ctrl.sv */
// Controller state machine of the record heap sorter.
`default_nettype none
module hsrk_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   input  wire logic [1:0]         req_cmd,
   output logic                    req_stall,
   output hsrk_pkg::op_type        op,
   input  wire hsrk_pkg::stat_type stat
);
   import hsrk_pkg::*;

   typedef enum logic [17:0] {
      S_IDLE       = 18'h00001,
      S_CHK        = 18'h00002,
      S_FILL_RD    = 18'h00004,
      S_FILL_WR    = 18'h00008,
      S_BUILD_INIT = 18'h00010,
      S_BUILD_RD   = 18'h00020,
      S_CUR        = 18'h00040,
      S_SIFT_L     = 18'h00080,
      S_SIFT_R     = 18'h00100,
      S_SIFT_C     = 18'h00200,
      S_AFTER      = 18'h00400,
      S_EX_M       = 18'h00800,
      S_EX_0       = 18'h01000,
      S_EX_W       = 18'h02000,
      S_EM_INIT    = 18'h04000,
      S_EM_RD      = 18'h08000,
      S_EM_REC     = 18'h10000,
      S_EM_OUT     = 18'h20000
   } state_type;

   state_type state_ff, state_in;
   logic      build_ff, build_in;

   // Next state and the datapath operation for this cycle.
   always_comb begin
      state_in = state_ff;
      build_in = build_ff;
      op       = OP_IDLE;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req_cmd == CMD_LOAD) begin
                  op = OP_LOAD;
               end else if (req_cmd == CMD_CLEAR) begin
                  op = OP_CLEAR;
               end else if (req_cmd == CMD_SORT) begin
                  op       = OP_START;
                  state_in = S_CHK;
               end
            end
         end
         S_CHK: begin
            state_in = stat.hsize_zero ? S_IDLE : S_FILL_RD;
         end
         S_FILL_RD: begin
            op       = OP_FILL_RD;
            state_in = S_FILL_WR;
         end
         S_FILL_WR: begin
            op       = OP_FILL_WR;
            state_in = stat.fill_last ? S_BUILD_INIT : S_FILL_RD;
         end
         S_BUILD_INIT: begin
            op       = OP_BUILD_INIT;
            state_in = stat.hsize_one ? S_EM_INIT : S_BUILD_RD;
         end
         S_BUILD_RD: begin
            op       = OP_BUILD_RD;
            build_in = 1'b1;
            state_in = S_CUR;
         end
         S_CUR: begin
            op       = OP_LOAD_CUR;
            state_in = S_SIFT_L;
         end
         S_SIFT_L: begin
            if (stat.l_ok) begin
               op       = OP_SIFT_RDL;
               state_in = S_SIFT_R;
            end else begin
               op       = OP_SIFT_PUT;
               state_in = S_AFTER;
            end
         end
         S_SIFT_R: begin
            op       = OP_SIFT_RDR;
            state_in = S_SIFT_C;
         end
         S_SIFT_C: begin
            op       = OP_SIFT_CMP;
            state_in = stat.sift_stop ? S_AFTER : S_SIFT_L;
         end
         S_AFTER: begin
            if (build_ff && !stat.j_zero) begin
               state_in = S_BUILD_RD;
            end else if (stat.hsize_one) begin
               state_in = S_EM_INIT;
            end else begin
               state_in = S_EX_M;
            end
         end
         S_EX_M: begin
            op       = OP_EX_RDM;
            build_in = 1'b0;
            state_in = S_EX_0;
         end
         S_EX_0: begin
            op       = OP_EX_RD0;
            state_in = S_EX_W;
         end
         S_EX_W: begin
            op       = OP_EX_WRM;
            state_in = S_SIFT_L;
         end
         S_EM_INIT: begin
            op       = OP_EM_INIT;
            state_in = S_EM_RD;
         end
         S_EM_RD: begin
            op       = OP_EM_RD;
            state_in = S_EM_REC;
         end
         S_EM_REC: begin
            op       = OP_EM_RREC;
            state_in = S_EM_OUT;
         end
         S_EM_OUT: begin
            if (stat.out_free) begin
               op       = OP_EM_OUT;
               state_in = stat.em_last ? S_IDLE : S_EM_RD;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         build_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         build_ff <= build_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);

endmodule
`default_nettype wire

/* hdl/heap_sort_records_by_key_core.sv */
// Top level of the record heap sorter: controller and datapath.
//
// Input items arrive on req_valid/req_stall/req and are taken only while the
// block is idle. A load item stores one record (dropped when the store is
// full); a clear item empties the store.
// A sort item copies the record indices and the selected keys into a heap
// memory, builds a min-heap and then moves the root to the end of the
// shrinking heap. Each sift-down level reads the left child, reads the right
// child, then compares and writes back into the heap memory.
// The records come out on rsp_valid/rsp_stall/rsp in descending key order,
// with last set on the final one; an empty store gives no result. A stalled
// result waits in the output register and the sequencer holds until it is
// taken. Reset empties the store and returns the block to idle; it needs no
// clearing pass.
`default_nettype none
module heap_sort_records_by_key_core #(
   parameter int MAX_RECORDS = 64
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire hsrk_pkg::req_type req,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output hsrk_pkg::rsp_type      rsp
);
   import hsrk_pkg::*;

   op_type   op;
   stat_type stat;

   hsrk_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_cmd   (req.cmd),
      .req_stall (req_stall),
      .op        (op),
      .stat      (stat)
   );

   hsrk_dp #(
      .MAX_RECORDS (MAX_RECORDS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .op        (op),
      .req       (req),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp       (rsp)
   );

endmodule
`default_nettype wire
